### hw/rtl/fmmp_pkg.sv
// ----------------------------------------------------------------------------
// fmmp_pkg
// Shared types, constants and helpers for the Fibonacci mod 1e9+7 block.
// ----------------------------------------------------------------------------
package fmmp_pkg;

    // index, value, tag and op widths
    localparam int INDEX_BITS = 63;
    localparam int VAL_BITS   = 30;
    localparam int TAG_BITS   = 3;   // eight product entries per exponent bit
    localparam int OP_BITS    = 4;   // two multiply-accumulate passes per entry

    // modulus and its widened forms for the correction step
    localparam logic [VAL_BITS-1:0] FIB_MOD = 30'd1000000007;
    localparam logic [31:0]         MOD_W   = {2'b00, FIB_MOD};
    localparam logic [31:0]         MOD_X2  = MOD_W << 1;

    // reciprocal for the Barrett estimate, floor(2^61 / modulus)
    localparam logic [31:0] BARRETT_M = 32'((64'd1 << 61) / 64'(FIB_MOD));

    // 2x2 matrix of residues
    typedef struct packed {
        logic [VAL_BITS-1:0] e00;
        logic [VAL_BITS-1:0] e01;
        logic [VAL_BITS-1:0] e10;
        logic [VAL_BITS-1:0] e11;
    } mat_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic               load;      // capture a new index
        logic               issue;     // start one multiply-accumulate
        logic [OP_BITS-1:0] op;        // which term of which entry
        logic               commit;    // move finished products into the matrices
        logic               out_load;  // capture the result for the output
    } ctrl_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic p_zero;     // exponent fully consumed
        logic pipe_busy;  // multiply-reduce unit still holds work
    } dp_status_t;

    // pick one entry of a matrix
    function automatic logic [VAL_BITS-1:0] mat_entry(input mat_t m, input logic row,
                                                      input logic col);
        logic [VAL_BITS-1:0] v;
        unique case ({row, col})
            2'b00:   v = m.e00;
            2'b01:   v = m.e01;
            2'b10:   v = m.e10;
            default: v = m.e11;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/fibonacci_mod_matrix_power.sv
// Each exponent bit costs 16 issues to the shared multiply-reduce unit, a pipeline
// drain, one commit and one check; indices 0 and 1 go straight to the result.
// One item at a time; a new index is taken once the last result is in the output
// register. Sync reset: control only.
// ----------------------------------------------------------------------------
// fibonacci_mod_matrix_power
// Fibonacci(index) mod 1000000007 by 2x2 matrix square-and-multiply.
// ----------------------------------------------------------------------------
module fibonacci_mod_matrix_power (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [fmmp_pkg::INDEX_BITS-1:0] s_index,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [fmmp_pkg::VAL_BITS-1:0]   m_fib_value
);
    import fmmp_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencer
    fmmp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // matrices, exponent and multiply-reduce unit
    fmmp_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .index     (s_index),
        .fib_value (m_fib_value)
    );

endmodule

### hw/rtl/fmmp_mulmod.sv
// ----------------------------------------------------------------------------
// fmmp_mulmod
// Pipelined multiply-add-reduce unit: (a * b + c) mod 1000000007.
// Four register stages, result written out after the final correction.
// ----------------------------------------------------------------------------
module fmmp_mulmod (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    input  logic [fmmp_pkg::TAG_BITS-1:0]    in_tag,
    input  logic [fmmp_pkg::VAL_BITS-1:0]    in_a,
    input  logic [fmmp_pkg::VAL_BITS-1:0]    in_b,
    input  logic [fmmp_pkg::VAL_BITS-1:0]    in_c,
    output logic                             out_valid,
    output logic [fmmp_pkg::TAG_BITS-1:0]    out_tag,
    output logic [fmmp_pkg::VAL_BITS-1:0]    out_value,
    output logic                             busy
);
    import fmmp_pkg::*;

    logic                v1_reg, v2_reg, v3_reg, v4_reg;
    logic [TAG_BITS-1:0] t1_reg, t2_reg, t3_reg, t4_reg;
    logic [60:0]         sum1_reg, sum1_next;
    logic [62:0]         est2_reg, est2_next;
    logic [31:0]         lo2_reg, lo3_reg;
    logic [31:0]         qp3_reg, qp3_next;
    logic [31:0]         r4_reg, r4_next;
    logic [59:0]         prod;
    logic [30:0]         sum_hi;
    logic [31:0]         quot;
    logic [61:0]         qp_full;
    logic [31:0]         r_fix1, r_fix2;

    // stage 1: product plus addend, below 2^61
    assign prod      = 60'(in_a) * 60'(in_b);
    assign sum1_next = 61'(prod) + 61'(in_c);

    // stage 2: quotient estimate from the upper bits
    assign sum_hi    = sum1_reg[60:30];
    assign est2_next = 63'(sum_hi) * 63'(BARRETT_M);

    // stage 3: estimate times modulus, only the low word is needed
    assign quot      = est2_reg[62:31];
    assign qp_full   = 62'(quot) * 62'(FIB_MOD);
    assign qp3_next  = qp_full[31:0];

    // stage 4: remainder, known to be below four times the modulus
    assign r4_next   = lo3_reg - qp3_reg;

    // final correction into 0..modulus-1
    assign r_fix1    = (r4_reg >= MOD_X2) ? (r4_reg - MOD_X2) : r4_reg;
    assign r_fix2    = (r_fix1 >= MOD_W) ? (r_fix1 - MOD_W) : r_fix1;

    assign out_valid = v4_reg;
    assign out_tag   = t4_reg;
    assign out_value = r_fix2[VAL_BITS-1:0];
    assign busy      = v1_reg | v2_reg | v3_reg | v4_reg;

    // stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        t1_reg   <= in_tag;
        sum1_reg <= sum1_next;
        t2_reg   <= t1_reg;
        est2_reg <= est2_next;
        lo2_reg  <= sum1_reg[31:0];
        t3_reg   <= t2_reg;
        qp3_reg  <= qp3_next;
        lo3_reg  <= lo2_reg;
        t4_reg   <= t3_reg;
        r4_reg   <= r4_next;
    end

endmodule

### hw/rtl/fmmp_datapath.sv
// ----------------------------------------------------------------------------
// fmmp_datapath
// Exponent, accumulator and base matrices, partial products and result
// register, around the shared multiply-reduce unit.
// ----------------------------------------------------------------------------
module fmmp_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  fmmp_pkg::ctrl_cmd_t             cmd,
    output fmmp_pkg::dp_status_t            status,
    input  logic [fmmp_pkg::INDEX_BITS-1:0] index,
    output logic [fmmp_pkg::VAL_BITS-1:0]   fib_value
);
    import fmmp_pkg::*;

    logic [INDEX_BITS-1:0] p_reg;
    mat_t                  acc_reg;
    mat_t                  base_reg;
    logic [VAL_BITS-1:0]   partial_reg [8];
    logic [VAL_BITS-1:0]   fib_value_reg;

    logic                  op_k;
    logic [TAG_BITS-1:0]   op_e;
    logic [VAL_BITS-1:0]   opnd_a, opnd_b, opnd_c;
    logic                  res_valid;
    logic [TAG_BITS-1:0]   res_tag;
    logic [VAL_BITS-1:0]   res_value;
    logic                  pipe_busy;
    logic                  index_zero;

    // operand selection: entries 0..3 are acc*base, 4..7 are base*base
    assign op_k   = cmd.op[OP_BITS-1];
    assign op_e   = cmd.op[TAG_BITS-1:0];
    assign opnd_a = op_e[2] ? mat_entry(base_reg, op_e[1], op_k)
                            : mat_entry(acc_reg, op_e[1], op_k);
    assign opnd_b = mat_entry(base_reg, op_k, op_e[0]);
    assign opnd_c = op_k ? partial_reg[op_e] : '0;

    fmmp_mulmod u_mulmod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cmd.issue),
        .in_tag    (op_e),
        .in_a      (opnd_a),
        .in_b      (opnd_b),
        .in_c      (opnd_c),
        .out_valid (res_valid),
        .out_tag   (res_tag),
        .out_value (res_value),
        .busy      (pipe_busy)
    );

    assign index_zero       = (index == '0);
    assign status.p_zero    = (p_reg == '0);
    assign status.pipe_busy = pipe_busy;
    assign fib_value        = fib_value_reg;

    // partial products land by entry tag
    always_ff @(posedge aclk) begin
        if (res_valid) begin
            partial_reg[res_tag] <= res_value;
        end
    end

    // exponent and matrices: index zero starts from a zero top-left entry
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            p_reg        <= index_zero ? '0 : (index - INDEX_BITS'(1));
            acc_reg.e00  <= index_zero ? '0 : VAL_BITS'(1);
            acc_reg.e01  <= '0;
            acc_reg.e10  <= '0;
            acc_reg.e11  <= VAL_BITS'(1);
            base_reg.e00 <= VAL_BITS'(1);
            base_reg.e01 <= VAL_BITS'(1);
            base_reg.e10 <= VAL_BITS'(1);
            base_reg.e11 <= '0;
        end else if (cmd.commit) begin
            p_reg <= p_reg >> 1;
            if (p_reg[0]) begin
                acc_reg.e00 <= partial_reg[0];
                acc_reg.e01 <= partial_reg[1];
                acc_reg.e10 <= partial_reg[2];
                acc_reg.e11 <= partial_reg[3];
            end
            base_reg.e00 <= partial_reg[4];
            base_reg.e01 <= partial_reg[5];
            base_reg.e10 <= partial_reg[6];
            base_reg.e11 <= partial_reg[7];
        end
    end

    // result capture
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            fib_value_reg <= acc_reg.e00;
        end
    end

endmodule

### hw/rtl/fmmp_ctrl.sv
// ----------------------------------------------------------------------------
// fmmp_ctrl
// Sequencer: per exponent bit issues sixteen multiply-accumulates, drains
// the multiply-reduce unit and commits; handles both handshakes.
// ----------------------------------------------------------------------------
module fmmp_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  logic                    m_ready,
    output fmmp_pkg::ctrl_cmd_t     cmd,
    input  fmmp_pkg::dp_status_t    status
);
    import fmmp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RUN,
        ST_DRAIN,
        ST_COMMIT,
        ST_FINISH
    } state_t;

    state_t             state_reg, state_next;
    logic [OP_BITS-1:0] op_reg, op_next;
    logic               m_valid_reg, m_valid_next;
    logic               out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        cmd          = '0;
        cmd.op       = op_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                op_next    = '0;
                state_next = status.p_zero ? ST_FINISH : ST_RUN;
            end
            ST_RUN: begin
                cmd.issue = 1'b1;
                op_next   = op_reg + OP_BITS'(1);
                if (op_reg == '1) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = ST_CHECK;
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid follows the result capture and the downstream take
    always_comb begin
        priority if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### sim/fibonacci_mod_matrix_power_tb.sv
// ----------------------------------------------------------------------------
// fibonacci_mod_matrix_power_tb
// Self-checking bench for the Fibonacci mod 1e9+7 block. Corner indices come
// first, then random indices biased toward short exponents. Every returned
// value is checked against a matrix-power residue computed in the bench.
// Both handshake sides stall at random.
// ----------------------------------------------------------------------------
module fibonacci_mod_matrix_power_tb;
    import fmmp_pkg::*;

    localparam int          IDLE_LIMIT   = 8000;
    localparam int          RANDOM_ITEMS = 1700;
    localparam int          DRAIN_EVERY  = 250;
    localparam int          TAIL_CYCLES  = 64;
    localparam int          CORNER_COUNT = 20;
    localparam logic [63:0] PRIME        = 64'(FIB_MOD);

    // expected fib values in item order, plus the matching indices for reports
    class fib_scoreboard;
        logic [VAL_BITS-1:0]   expected_fib[$];
        logic [INDEX_BITS-1:0] pending_index[$];
        int unsigned           indices_seen;
        int unsigned           values_seen;
        int unsigned           mismatches;

        // one product entry: two multiply-accumulate terms, reduced after each
        function logic [VAL_BITS-1:0] mod_dot(input logic [VAL_BITS-1:0] a0, b0, a1, b1);
            logic [63:0] sum;
            sum = (64'(a0) * 64'(b0)) % PRIME;
            sum = (sum + 64'(a1) * 64'(b1)) % PRIME;
            return sum[VAL_BITS-1:0];
        endfunction

        function mat_t mat_product(input mat_t x, input mat_t y);
            mat_t r;
            r.e00 = mod_dot(x.e00, y.e00, x.e01, y.e10);
            r.e01 = mod_dot(x.e00, y.e01, x.e01, y.e11);
            r.e10 = mod_dot(x.e10, y.e00, x.e11, y.e10);
            r.e11 = mod_dot(x.e10, y.e01, x.e11, y.e11);
            return r;
        endfunction

        // fib(n) mod prime by square-and-multiply, exponent scanned lsb first
        function logic [VAL_BITS-1:0] fib_residue(input logic [INDEX_BITS-1:0] n);
            mat_t                  step;
            mat_t                  power;
            logic [INDEX_BITS-1:0] exp_left;
            if (n == 0) return '0;
            if (n == 1) return 1;
            step     = {30'd1, 30'd1, 30'd1, 30'd0};
            power    = {30'd1, 30'd0, 30'd0, 30'd1};
            exp_left = n - 1'b1;
            for (int b = 0; b < INDEX_BITS && exp_left != 0; b++) begin
                if (exp_left[0]) power = mat_product(power, step);
                step     = mat_product(step, step);
                exp_left = exp_left >> 1;
            end
            return power.e00;
        endfunction

        function void note_index(input logic [INDEX_BITS-1:0] n);
            expected_fib.push_back(fib_residue(n));
            pending_index.push_back(n);
            indices_seen++;
        endfunction

        function void check_result(input logic [VAL_BITS-1:0] got);
            logic [VAL_BITS-1:0]   want;
            logic [INDEX_BITS-1:0] n;
            values_seen++;
            if (expected_fib.size() == 0) begin
                mismatches++;
                $display("%0t: fib_value with no item pending: expected none, actual %0d",
                         $time, got);
                return;
            end
            want = expected_fib.pop_front();
            n    = pending_index.pop_front();
            if (got !== want) begin
                mismatches++;
                $display("%0t: fib_value mismatch for index %0d: expected %0d, actual %0d",
                         $time, n, want, got);
            end
        endfunction

        function int pending();
            return expected_fib.size();
        endfunction
    endclass

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [INDEX_BITS-1:0] s_index = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [VAL_BITS-1:0]   m_fib_value;

    fib_scoreboard fib_board;
    int            idle_cycles  = 0;
    int            tx_quiet     = 0;
    int            rx_quiet     = 0;
    int unsigned   wide_indices = 0;
    int unsigned   hold_offs    = 0;

    logic [INDEX_BITS-1:0] corner_idx [CORNER_COUNT] = '{
        63'd0, 63'd1, 63'd2, 63'd3, 63'd4, 63'd5, 63'd6, 63'd10,
        63'd47, 63'd48, 63'd90, 63'd1000000007, 63'd1000000008,
        63'h8000_0000, 63'h1_0000_0001,
        63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA,
        63'h4000_0000_0000_0000, 63'h7FFF_FFFF_FFFF_FFFE, 63'h7FFF_FFFF_FFFF_FFFF
    };

    fibonacci_mod_matrix_power dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_index     (s_index),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_fib_value (m_fib_value)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // stall length per item, with occasional stretches of back-to-back items
    function automatic int draw_gap(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(15) == 0) quiet_left = $urandom_range(30, 5);
        return $urandom_range(12);
    endfunction

    // mostly short exponents to keep latency down, a tenth up to full width
    function automatic logic [INDEX_BITS-1:0] random_index();
        int unsigned pick;
        int unsigned len;
        logic [63:0] raw;
        pick = $urandom_range(99);
        if (pick < 8)       len = $urandom_range(2);
        else if (pick < 65) len = $urandom_range(12, 3);
        else if (pick < 90) len = $urandom_range(30, 13);
        else                len = $urandom_range(63, 31);
        raw = {$urandom, $urandom};
        if (len == 0) return '0;
        raw          = raw & ((64'd1 << len) - 64'd1);
        raw[len-1]   = 1'b1;
        return raw[INDEX_BITS-1:0];
    endfunction

    // offer one index and hold it until taken
    task automatic send_index(input logic [INDEX_BITS-1:0] n);
        int gap;
        gap = draw_gap(tx_quiet);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_index <= n;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    // stop sending until every outstanding value has come back
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        hold_offs++;
        do @(posedge aclk); while (fib_board.pending() != 0);
    endtask

    // result side back-pressure, sometimes stalling while valid is held
    initial begin
        int gap;
        do @(posedge aclk); while (!aresetn);
        forever begin
            gap = draw_gap(rx_quiet);
            if (gap > 0) begin
                m_ready <= 1'b0;
                if ($urandom_range(1) == 0) begin
                    do @(posedge aclk); while (!m_valid);
                end
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // capture accepted items on both channels
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) fib_board.note_index(s_index);
            if (m_valid && m_ready) fib_board.check_result(m_fib_value);
        end
    end

    // hang detection: cycles with no item moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d values outstanding",
                     $time, idle_cycles, fib_board.pending());
            $display("fibonacci_mod_matrix_power test failed");
            $finish;
        end
    end

    // main sequence
    initial begin
        logic [INDEX_BITS-1:0] n;
        fib_board = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // corner indices
        foreach (corner_idx[i]) send_index(corner_idx[i]);
        hold_until_drained();

        // random indices with periodic full drains
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % DRAIN_EVERY == DRAIN_EVERY - 1) hold_until_drained();
            n = random_index();
            if (n >= 63'h8000_0000) wide_indices++;
            send_index(n);
        end
        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("checked %0d indices (%0d corner, %0d above 2^31) against %0d values",
                 fib_board.indices_seen, CORNER_COUNT, wide_indices, fib_board.values_seen);
        $display("sender held off %0d times until all values returned, %0d mismatches",
                 hold_offs, fib_board.mismatches);
        if (fib_board.mismatches == 0 && fib_board.pending() == 0) begin
            $display("fibonacci_mod_matrix_power test passed");
        end else begin
            $display("fibonacci_mod_matrix_power test failed");
        end
        $finish;
    end

endmodule
